FILE: src/bmii_pkg.sv
`default_nettype none

package bmii_pkg;

  // Field and register widths.
  localparam int COUNT_W  = 21;
  localparam int ROWSUM_W = 11;
  localparam int CFG_W    = 11;

  // Largest count a result word can carry; larger sums saturate here.
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Size both registers take after reset.
  localparam int CFG_RESET_SIZE = 1024;

  // Default grid limits for the top-level parameters.
  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_MAX_ROWS    = 1024;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_GRID_COLUMNS = 1'b0,
    CFG_GRID_ROWS    = 1'b1
  } cfg_index_t;

  // Per-cell information handed from the scan stage to the accumulate stage.
  typedef struct packed {
    logic [ROWSUM_W-1:0] row_sum;
    logic                first_row;
    logic                frame_end;
  } bmii_item_t;

endpackage

`default_nettype wire

FILE: src/binary_mask_integral_image_top.sv
`default_nettype none
// Summed-area table over a raster stream of one-bit flags.
// Words pass through the cell stage register and then the output register.
// Throughput: one flag per cycle unless stalled; line store read and written once per cycle.
// Reset: positions and row sum clear, both sizes return to at most 1024; the line store
// is not cleared because the first row of each frame never uses it.

module binary_mask_integral_image_top
  import bmii_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic               mark_valid,
  output      logic               mark_stall,
  input  wire logic               mark_bit,
  output      logic               area_valid,
  input  wire logic               area_stall,
  output      logic [COUNT_W-1:0] area_count,
  output      logic               frame_end
);

  localparam int CW = $clog2(MAX_COLUMNS);

  logic               accept;
  logic [CW-1:0]      col;
  bmii_item_t         item;
  logic [COUNT_W-1:0] rd_data;
  logic               wr_en;
  logic [CW-1:0]      wr_addr;
  logic [COUNT_W-1:0] wr_data;
  logic               hold;

  // A word enters whenever the cell stage can take it.
  assign mark_stall = hold;
  assign accept     = mark_valid && !hold;

  bmii_scan #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (accept),
    .mark_bit (mark_bit),
    .col      (col),
    .item     (item)
  );

  // Line store of the previous row's counts.
  bmii_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(MAX_COLUMNS)
  ) u_line (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (accept),
    .raddr(col),
    .rdata(rd_data)
  );

  bmii_accum #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .col       (col),
    .item      (item),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .hold      (hold),
    .area_valid(area_valid),
    .area_stall(area_stall),
    .area_count(area_count),
    .frame_end (frame_end)
  );

endmodule

`default_nettype wire

FILE: src/bmii_ram.sv
`default_nettype none

module bmii_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/bmii_scan.sv
`default_nettype none

module bmii_scan
  import bmii_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [0:0]                     cfg_index,
  input  wire logic [CFG_W-1:0]               cfg_data,
  input  wire logic                           accept,
  input  wire logic                           mark_bit,
  output      logic [$clog2(MAX_COLUMNS)-1:0] col,
  output      bmii_item_t                     item
);

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam logic [CW-1:0] RESET_LAST_COL =
    CW'(((CFG_RESET_SIZE > MAX_COLUMNS) ? MAX_COLUMNS : CFG_RESET_SIZE) - 1);
  localparam logic [RW-1:0] RESET_LAST_ROW =
    RW'(((CFG_RESET_SIZE > MAX_ROWS) ? MAX_ROWS : CFG_RESET_SIZE) - 1);

  logic [CW-1:0]       last_col_idx, last_col_idx_next;
  logic [RW-1:0]       last_row_idx, last_row_idx_next;
  logic [CW-1:0]       col_next;
  logic [RW-1:0]       row, row_next;
  logic [ROWSUM_W-1:0] row_sum, row_sum_next;
  logic [ROWSUM_W-1:0] sum_with_bit;
  logic                last_col, last_row;
  logic [CW-1:0]       cfg_last_col;
  logic [RW-1:0]       cfg_last_row;

  // Clamp a written size to 1..max and keep it as the index of the last cell.
  always_comb begin
    if (cfg_data == '0) begin
      cfg_last_col = '0;
    end else if (32'(cfg_data) > MAX_COLUMNS) begin
      cfg_last_col = CW'(MAX_COLUMNS - 1);
    end else begin
      cfg_last_col = CW'(cfg_data - 1'b1);
    end
    if (cfg_data == '0) begin
      cfg_last_row = '0;
    end else if (32'(cfg_data) > MAX_ROWS) begin
      cfg_last_row = RW'(MAX_ROWS - 1);
    end else begin
      cfg_last_row = RW'(cfg_data - 1'b1);
    end
  end

  // Current cell position and the row's running flag count.
  always_comb begin
    last_col     = (col == last_col_idx);
    last_row     = (row == last_row_idx);
    sum_with_bit = row_sum + ROWSUM_W'(mark_bit);

    item.row_sum   = sum_with_bit;
    item.first_row = (row == '0);
    item.frame_end = last_col && last_row;
  end

  // Register writes restart the frame; accepted words advance the raster.
  always_comb begin
    last_col_idx_next = last_col_idx;
    last_row_idx_next = last_row_idx;
    col_next          = col;
    row_next          = row;
    row_sum_next      = row_sum;
    if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_GRID_COLUMNS: last_col_idx_next = cfg_last_col;
        CFG_GRID_ROWS:    last_row_idx_next = cfg_last_row;
        default:          last_col_idx_next = last_col_idx;
      endcase
      col_next     = '0;
      row_next     = '0;
      row_sum_next = '0;
    end else if (accept) begin
      if (last_col) begin
        col_next     = '0;
        row_sum_next = '0;
        row_next     = last_row ? '0 : row + 1'b1;
      end else begin
        col_next     = col + 1'b1;
        row_sum_next = sum_with_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col_idx <= RESET_LAST_COL;
      last_row_idx <= RESET_LAST_ROW;
      col          <= '0;
      row          <= '0;
      row_sum      <= '0;
    end else begin
      last_col_idx <= last_col_idx_next;
      last_row_idx <= last_row_idx_next;
      col          <= col_next;
      row          <= row_next;
      row_sum      <= row_sum_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/bmii_accum.sv
`default_nettype none

module bmii_accum
  import bmii_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           accept,
  input  wire logic [$clog2(MAX_COLUMNS)-1:0] col,
  input  wire bmii_item_t                     item,
  input  wire logic [COUNT_W-1:0]             rd_data,
  output      logic                           wr_en,
  output      logic [$clog2(MAX_COLUMNS)-1:0] wr_addr,
  output      logic [COUNT_W-1:0]             wr_data,
  output      logic                           hold,
  output      logic                           area_valid,
  input  wire logic                           area_stall,
  output      logic [COUNT_W-1:0]             area_count,
  output      logic                           frame_end
);

  localparam int CW = $clog2(MAX_COLUMNS);

  logic               s1_valid;
  bmii_item_t         s1_item;
  logic [CW-1:0]      s1_addr;
  logic               fwd_hit;
  logic [COUNT_W-1:0] fwd_val;
  logic [COUNT_W-1:0] above;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] count;
  logic               advance;

  // Count above the cell: zero on the first row, else the line store,
  // bypassed when the previous word wrote this same column.
  always_comb begin
    if (s1_item.first_row) begin
      above = '0;
    end else if (fwd_hit) begin
      above = fwd_val;
    end else begin
      above = rd_data;
    end
    sum   = {1'b0, above} + (COUNT_W + 1)'(s1_item.row_sum);
    count = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
  end

  // Handshake: the cell stage moves on whenever the output register frees.
  always_comb begin
    advance = !(area_valid && area_stall);
    hold    = s1_valid && !advance;
    wr_en   = s1_valid && advance;
    wr_addr = s1_addr;
    wr_data = count;
  end

  // Control registers of the two stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      area_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        area_valid <= s1_valid;
      end
    end
  end

  // Payload registers: cell stage, bypass and output word.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
      s1_addr <= col;
      fwd_hit <= wr_en && (s1_addr == col);
      fwd_val <= count;
    end
    if (advance && s1_valid) begin
      area_count <= count;
      frame_end  <= s1_item.frame_end;
    end
  end

endmodule

`default_nettype wire
